>>> src/phv_pkg.sv
// ----------------------------------------------------------------------------
// phv_pkg
// shared types and constants of the authorization-data header validator
// ----------------------------------------------------------------------------
package phv_pkg;

   localparam int STATUS_W    = 4;
   localparam int IDX_W       = 6;
   localparam int WORD_W      = 32;
   localparam int COUNT_BYTES = 4;
   localparam int HDR_BASE    = 8;
   localparam int ENTRY_BYTES = 16;

   localparam logic [WORD_W-1:0] TYPE_SERVER  = 32'd6;
   localparam logic [WORD_W-1:0] TYPE_PRIVSVR = 32'd7;
   localparam logic [WORD_W-1:0] TYPE_LOGON   = 32'd10;

   typedef enum logic [STATUS_W-1:0] {
      ST_IDLE         = 4'd0,
      ST_MORE         = 4'd1,
      ST_ACCEPT       = 4'd2,
      ST_TRUNC        = 4'd3,
      ST_FEW          = 4'd4,
      ST_VERSION      = 4'd5,
      ST_HDRLONG      = 4'd6,
      ST_TOOMANY      = 4'd7,
      ST_ALIGN        = 4'd8,
      ST_HIGHOFF      = 4'd9,
      ST_PASTEND      = 4'd10,
      ST_INHDR        = 4'd11,
      ST_SIZE         = 4'd12,
      ST_DUP_SERVER   = 4'd13,
      ST_DUP_PRIVSVR  = 4'd14,
      ST_DUP_LOGON    = 4'd15
   } status_type;

   typedef enum logic [1:0] {
      STAGE_COUNT   = 2'd0,
      STAGE_VERSION = 2'd1,
      STAGE_ENTRY   = 2'd2
   } stage_type;

   // special entry kinds, the code doubles as the found-flag bit
   typedef enum logic [1:0] {
      SLOT_SERVER  = 2'd0,
      SLOT_PRIVSVR = 2'd1,
      SLOT_LOGON   = 2'd2,
      SLOT_NONE    = 2'd3
   } slot_type;

   typedef struct packed {
      status_type status;
      slot_type   slot;
   } check_type;

   // result payload, status in the lowest bits
   typedef struct packed {
      logic [6:0]       pad;
      logic [IDX_W-1:0] logon_idx;
      logic [IDX_W-1:0] privsvr_idx;
      logic [IDX_W-1:0] server_idx;
      logic             has_logon;
      logic             has_privsvr;
      logic             has_server;
      status_type       status;
   } rsp_type;

endpackage

>>> src/phv_entry_check.sv
// ----------------------------------------------------------------------------
// phv_entry_check
// bounds, alignment and duplicate checks on one completed buffer entry
// ----------------------------------------------------------------------------
module phv_entry_check #(
   parameter int HDR_W = 11
) (
   input  phv_pkg::slot_type          kind,
   input  logic [31:0]                entry_size,
   input  logic [31:0]                entry_offset,
   input  logic [31:0]                offset_high,
   input  logic [31:0]                held_length,
   input  logic [HDR_W-1:0]           hdr_bound,
   input  logic [2:0]                 found_flags,
   output phv_pkg::check_type         result
);
   import phv_pkg::*;

   logic [WORD_W-1:0] room;
   logic              dup;

   assign room = held_length - entry_offset;

   always_comb begin
      dup = 1'b0;
      case (kind)
         SLOT_SERVER:  dup = found_flags[0];
         SLOT_PRIVSVR: dup = found_flags[1];
         SLOT_LOGON:   dup = found_flags[2];
         default:      dup = 1'b0;
      endcase
   end

   always_comb begin
      result.slot    = kind;
      if (entry_offset[2:0] != 3'd0) begin
         result.status = ST_ALIGN;
      end else if (offset_high != '0) begin
         result.status = ST_HIGHOFF;
      end else if (entry_offset > held_length) begin
         result.status = ST_PASTEND;
      end else if (entry_offset < WORD_W'(hdr_bound)) begin
         result.status = ST_INHDR;
      end else if (entry_size > room) begin
         result.status = ST_SIZE;
      end else if (dup) begin
         case (kind)
            SLOT_SERVER:  result.status = ST_DUP_SERVER;
            SLOT_PRIVSVR: result.status = ST_DUP_PRIVSVR;
            default:      result.status = ST_DUP_LOGON;
         endcase
      end else begin
         result.status = ST_MORE;
      end
   end

endmodule

>>> src/pac_header_validator.sv
// ----------------------------------------------------------------------------
// pac_header_validator
// streaming header check for authorization-data blobs
// ----------------------------------------------------------------------------
// Header words enter one per transfer on the req_ side, the first word of a
// blob flagged by req_tuser together with the blob length in the upper half
// of req_tdata. Every word gives exactly one result transfer on the rsp_ side
// carrying a status (need more, accepted, or the first error found); on
// acceptance it also carries which of the server checksum, privileged
// checksum and logon name entries were seen and their entry indices. The
// whole check of a word is one registered pass, so a word can be taken every
// cycle while req_tready is high. Its result is registered; the register is
// backed by a one-entry skid stage, so one more word is still taken while a
// result waits; req_tready drops only when both are full. A start word always
// abandons a blob in progress; a word outside a blob answers idle.
// ----------------------------------------------------------------------------
module pac_header_validator #(
   parameter int MAX_BUFFERS = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // data_word [31:0], blob_length [63:32]
   input  logic [0:0]  req_tuser,   // start_flag [0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata    // status [3:0], has_server_sum [4],
                                    // has_privsvr_sum [5], has_logon_name [6],
                                    // server_sum_index [12:7],
                                    // privsvr_sum_index [18:13],
                                    // logon_name_index [24:19], zero [31:25]
);
   import phv_pkg::*;

   // counter width holds the saturated count, header end holds 8 + 16 * max
   localparam int BW    = $clog2(MAX_BUFFERS + 2);
   localparam int HDR_W = $clog2(HDR_BASE + ENTRY_BYTES * MAX_BUFFERS + 1);

   // input fields
   logic              start;
   logic [WORD_W-1:0] word;
   logic [WORD_W-1:0] blen;
   logic              accept;

   assign start  = req_tuser[0];
   assign word   = req_tdata[31:0];
   assign blen   = req_tdata[63:32];
   assign accept = req_tvalid & req_tready;

   // parser state
   logic              active_ff, active_in;
   stage_type         stage_ff, stage_in;
   logic [1:0]        field_ff, field_in;
   logic [BW-1:0]     counter_ff, counter_in;
   logic [BW-1:0]     total_ff, total_in;
   logic [HDR_W-1:0]  hdr_end_ff, hdr_end_in;
   logic [WORD_W-1:0] held_ff, held_in;
   slot_type          kind_ff, kind_in;
   logic [WORD_W-1:0] size_ff, size_in;
   logic [WORD_W-1:0] offset_ff, offset_in;
   logic [2:0]        found_ff, found_in;
   logic [IDX_W-1:0]  idx_ff [3];
   logic [IDX_W-1:0]  idx_in [3];

   // state as seen by this word, a start word sees a fresh blob
   logic              act_e;
   stage_type         stage_e;
   logic [1:0]        field_e;
   logic [BW-1:0]     counter_e;
   logic [2:0]        found_e;
   logic [WORD_W-1:0] held_e;

   assign act_e     = start | active_ff;
   assign stage_e   = start ? STAGE_COUNT : stage_ff;
   assign field_e   = start ? 2'd0 : field_ff;
   assign counter_e = start ? '0 : counter_ff;
   assign found_e   = start ? 3'd0 : found_ff;
   assign held_e    = start ? blen : held_ff;

   status_type status;
   check_type  chk;

   phv_entry_check #(
      .HDR_W(HDR_W)
   ) u_check (
      .kind        (kind_ff),
      .entry_size  (size_ff),
      .entry_offset(offset_ff),
      .offset_high (word),
      .held_length (held_e),
      .hdr_bound   (hdr_end_ff),
      .found_flags (found_e),
      .result      (chk)
   );

   // word datapath and status
   always_comb begin
      status     = ST_IDLE;
      field_in   = field_e;
      counter_in = counter_e;
      total_in   = start ? '0 : total_ff;
      hdr_end_in = start ? '0 : hdr_end_ff;
      held_in    = held_e;
      kind_in    = kind_ff;
      size_in    = size_ff;
      offset_in  = offset_ff;
      found_in   = found_e;
      for (int i = 0; i < 3; i++) begin
         idx_in[i] = start ? '0 : idx_ff[i];
      end
      if (act_e) begin
         case (stage_e)
            STAGE_COUNT: begin
               // counts beyond the limit saturate so they are flagged, not wrapped
               total_in = (word > WORD_W'(MAX_BUFFERS)) ? BW'(MAX_BUFFERS + 1) : BW'(word);
               status   = (held_e < WORD_W'(COUNT_BYTES)) ? ST_TRUNC : ST_MORE;
            end
            STAGE_VERSION: begin
               field_in = 2'd0;
               if (held_e < WORD_W'(HDR_BASE)) begin
                  status = ST_TRUNC;
               end else if (total_ff == '0) begin
                  status = ST_FEW;
               end else if (word != '0) begin
                  status = ST_VERSION;
               end else if (total_ff > BW'(MAX_BUFFERS)) begin
                  status = ST_TOOMANY;
               end else begin
                  hdr_end_in = HDR_W'(HDR_BASE) + HDR_W'(total_ff) * HDR_W'(ENTRY_BYTES);
                  status     = (WORD_W'(hdr_end_in) > held_e) ? ST_HDRLONG : ST_MORE;
               end
            end
            STAGE_ENTRY: begin
               field_in = field_e + 2'd1;
               case (field_e)
                  2'd0: begin
                     status = ST_MORE;
                     if (word == TYPE_SERVER) begin
                        kind_in = SLOT_SERVER;
                     end else if (word == TYPE_PRIVSVR) begin
                        kind_in = SLOT_PRIVSVR;
                     end else if (word == TYPE_LOGON) begin
                        kind_in = SLOT_LOGON;
                     end else begin
                        kind_in = SLOT_NONE;
                     end
                  end
                  2'd1: begin
                     status  = ST_MORE;
                     size_in = word;
                  end
                  2'd2: begin
                     status    = ST_MORE;
                     offset_in = word;
                  end
                  default: begin
                     // offset high word closes the entry
                     status = chk.status;
                     if (chk.status == ST_MORE) begin
                        case (chk.slot)
                           SLOT_SERVER: begin
                              found_in[0] = 1'b1;
                              idx_in[0]   = IDX_W'(counter_e);
                           end
                           SLOT_PRIVSVR: begin
                              found_in[1] = 1'b1;
                              idx_in[1]   = IDX_W'(counter_e);
                           end
                           SLOT_LOGON: begin
                              found_in[2] = 1'b1;
                              idx_in[2]   = IDX_W'(counter_e);
                           end
                           default: begin
                           end
                        endcase
                        counter_in = counter_e + BW'(1);
                        if (counter_in >= total_ff) begin
                           status = ST_ACCEPT;
                        end
                     end
                  end
               endcase
            end
            default: status = ST_IDLE;
         endcase
      end
   end

   // next parser stage, any status other than need more ends the blob
   always_comb begin
      stage_in  = stage_e;
      active_in = act_e && (status == ST_MORE);
      if (act_e) begin
         case (stage_e)
            STAGE_COUNT:   stage_in = STAGE_VERSION;
            STAGE_VERSION: stage_in = STAGE_ENTRY;
            default:       stage_in = stage_e;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff  <= 1'b0;
         stage_ff   <= STAGE_COUNT;
         field_ff   <= 2'd0;
         counter_ff <= '0;
         total_ff   <= '0;
         hdr_end_ff <= '0;
         held_ff    <= '0;
         found_ff   <= 3'd0;
         for (int i = 0; i < 3; i++) begin
            idx_ff[i] <= '0;
         end
      end else if (accept) begin
         active_ff  <= active_in;
         stage_ff   <= stage_in;
         field_ff   <= field_in;
         counter_ff <= counter_in;
         total_ff   <= total_in;
         hdr_end_ff <= hdr_end_in;
         held_ff    <= held_in;
         found_ff   <= found_in;
         for (int i = 0; i < 3; i++) begin
            idx_ff[i] <= idx_in[i];
         end
      end
   end

   // entry words need no reset, they are always written before use
   always_ff @(posedge clock) begin
      if (accept) begin
         kind_ff   <= kind_in;
         size_ff   <= size_in;
         offset_ff <= offset_in;
      end
   end

   // result payload, everything but the status is zero unless accepted
   rsp_type result;

   always_comb begin
      result        = '0;
      result.status = status;
      if (status == ST_ACCEPT) begin
         result.has_server  = found_in[0];
         result.has_privsvr = found_in[1];
         result.has_logon   = found_in[2];
         result.server_idx  = idx_in[0];
         result.privsvr_idx = idx_in[1];
         result.logon_idx   = idx_in[2];
      end
   end

   // result register with a one-entry skid stage behind it
   logic    rsp_valid_ff, skid_valid_ff;
   rsp_type rsp_data_ff, skid_data_ff;
   logic    pop;

   assign pop        = rsp_valid_ff & rsp_tready;
   assign req_tready = ~skid_valid_ff;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (pop) begin
            skid_valid_ff <= 1'b0;
         end
      end else if (accept) begin
         if (!rsp_valid_ff || pop) begin
            rsp_valid_ff <= 1'b1;
         end else begin
            skid_valid_ff <= 1'b1;
         end
      end else if (pop) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (pop) begin
            rsp_data_ff <= skid_data_ff;
         end
      end else if (accept) begin
         if (!rsp_valid_ff || pop) begin
            rsp_data_ff <= result;
         end else begin
            skid_data_ff <= result;
         end
      end
   end

   // the skid stage only fills behind a waiting result
   assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff)
      else $error("skid stage holds a result with the result register empty");

   // a count word never leaves the parser still waiting for a count
   assert property (@(posedge clock) disable iff (reset)
      active_ff |-> (stage_ff != STAGE_COUNT))
      else $error("active blob parked at the count stage");

   // completed entries never pass the buffer count
   assert property (@(posedge clock) disable iff (reset)
      counter_ff <= total_ff)
      else $error("entry counter beyond buffer count");

   // entry fields are zero on every result but acceptance
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_data_ff.status != ST_ACCEPT)) |-> (rsp_data_ff[24:4] == '0))
      else $error("entry fields set on a result other than acceptance");

   // a word taken while the result is stalled lands in the skid stage
   assert property (@(posedge clock) disable iff (reset)
      (accept && rsp_valid_ff && !rsp_tready) |=> skid_valid_ff)
      else $error("stalled result not backed by the skid stage");

endmodule

>>> test/pac_header_validator_tb.sv
// ----------------------------------------------------------------------------
// pac_header_validator_tb
// self-checking bench for the authorization-data header validator
// ----------------------------------------------------------------------------
// A table of directed header words runs first: error codes, idle words and
// the size extremes. Random blobs follow, most of them well formed with
// random content, some cut short, some carrying one flawed entry. A parser
// model in the bench predicts the status of every accepted word, and each
// result transfer is checked field by field against the oldest prediction.
// Both sides idle at random. There is one long receiver hold-off and one
// pause of the sender until all results are in.
// ----------------------------------------------------------------------------
module pac_header_validator_tb;

   import phv_pkg::*;

   localparam int MAX_BUFFERS      = 64;
   localparam int TOTAL_WORDS      = 820;     // accepted words, at least
   localparam int SINK_HOLD_CYCLES = 60;
   localparam int DRAIN_SLACK      = 10;
   localparam int CYCLE_LIMIT      = 600000;

   // word position inside a buffer entry
   localparam logic [1:0] FIELD_TYPE   = 2'd0;
   localparam logic [1:0] FIELD_SIZE   = 2'd1;
   localparam logic [1:0] FIELD_OFFSET = 2'd2;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata  = '0;   // data_word [31:0], blob_length [63:32]
   logic [0:0]  req_tuser  = '0;   // start_flag [0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;         // status [3:0], has_server_sum [4],
                                   // has_privsvr_sum [5], has_logon_name [6],
                                   // server_sum_index [12:7],
                                   // privsvr_sum_index [18:13],
                                   // logon_name_index [24:19], zero [31:25]

   pac_header_validator #(
      .MAX_BUFFERS (MAX_BUFFERS)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ------------------------------------------------------------------------
   // parser model state
   // ------------------------------------------------------------------------
   bit               in_blob;
   stage_type        parse_stage;
   logic [1:0]       word_pos;
   int unsigned      entries_done;
   int unsigned      count_sat;      // buffer count, saturated above the max
   logic [31:0]      hdr_end;
   logic [31:0]      held_len;
   logic [31:0]      cur_kind;
   logic [31:0]      cur_size;
   logic [31:0]      cur_offset;
   logic [2:0]       seen;           // server, privsvr, logon name
   logic [IDX_W-1:0] seen_idx [3];

   rsp_type awaited_rsp [$];         // predicted results, oldest first
   int      mismatch_count = 0;
   int      sent_words     = 0;      // accepted words
   int      cycle_count    = 0;
   int      sender_burst   = 0;      // words still to send back to back
   bit      sink_hold_req  = 1'b0;

   // directed words, expected status typed in where it is obvious
   typedef struct {
      bit          start;
      logic [31:0] word;
      logic [31:0] len;
      bit          typed;
      status_type  want;
   } script_row_type;

   script_row_type directed_rows [26] = '{
      '{1'b0, 32'h1234_5678, 32'd100,       1'b1, ST_IDLE},     // no blob yet
      '{1'b1, 32'd1,         32'd0,         1'b1, ST_TRUNC},    // no room for count
      '{1'b1, 32'd0,         32'd8,         1'b0, ST_MORE},
      '{1'b0, 32'd0,         32'd0,         1'b1, ST_FEW},      // zero buffers
      '{1'b1, 32'd1,         32'd7,         1'b0, ST_MORE},
      '{1'b0, 32'd0,         32'd0,         1'b1, ST_TRUNC},    // no room for version
      '{1'b1, 32'd2,         32'd100,       1'b0, ST_MORE},
      '{1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, ST_VERSION},
      '{1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, ST_MORE},
      '{1'b0, 32'd0,         32'd0,         1'b1, ST_TOOMANY},  // count not wrapped
      '{1'b1, 32'd64,        32'd1031,      1'b0, ST_MORE},
      '{1'b1, 32'd64,        32'd1032,      1'b0, ST_MORE},     // restart mid blob
      '{1'b0, 32'd0,         32'd0,         1'b0, ST_MORE},     // header fits exactly
      '{1'b1, 32'd64,        32'd1031,      1'b0, ST_MORE},
      '{1'b0, 32'd0,         32'd0,         1'b1, ST_HDRLONG},  // one byte short
      '{1'b1, 32'd2,         32'd64,        1'b0, ST_MORE},     // two entries
      '{1'b0, 32'd0,         32'd0,         1'b0, ST_MORE},
      '{1'b0, TYPE_SERVER,   32'd0,         1'b0, ST_MORE},
      '{1'b0, 32'd8,         32'd0,         1'b0, ST_MORE},
      '{1'b0, 32'd40,        32'd0,         1'b0, ST_MORE},     // right at header end
      '{1'b0, 32'd0,         32'd0,         1'b0, ST_MORE},
      '{1'b0, TYPE_LOGON,    32'd0,         1'b0, ST_MORE},
      '{1'b0, 32'd16,        32'd0,         1'b0, ST_MORE},     // ends at blob end
      '{1'b0, 32'd48,        32'd0,         1'b0, ST_MORE},
      '{1'b0, 32'd0,         32'd0,         1'b0, ST_MORE},     // last entry closes
      '{1'b0, 32'hDEAD_BEEF, 32'd0,         1'b1, ST_IDLE}      // after acceptance
   };

   function automatic void clear_parse();
      in_blob      = 1'b0;
      parse_stage  = STAGE_COUNT;
      word_pos     = FIELD_TYPE;
      entries_done = 0;
      count_sat    = 0;
      hdr_end      = '0;
      held_len     = '0;
      cur_kind     = '0;
      cur_size     = '0;
      cur_offset   = '0;
      seen         = '0;
      seen_idx     = '{default: '0};
   endfunction

   // status and report of one accepted header word, model state advances
   function automatic rsp_type predict_word(bit start, logic [31:0] word,
                                            logic [31:0] len);
      status_type st;
      slot_type   slot;
      rsp_type    r;
      st = ST_IDLE;
      r  = '0;
      if (start) begin
         clear_parse();
         held_len = len;
         in_blob  = 1'b1;
      end
      if (in_blob) begin
         case (parse_stage)
            STAGE_COUNT: begin
               count_sat   = (word > MAX_BUFFERS) ? MAX_BUFFERS + 1 : word;
               st          = (held_len < COUNT_BYTES) ? ST_TRUNC : ST_MORE;
               parse_stage = STAGE_VERSION;
            end
            STAGE_VERSION: begin
               if (held_len < HDR_BASE)            st = ST_TRUNC;
               else if (count_sat == 0)            st = ST_FEW;
               else if (word != 0)                 st = ST_VERSION;
               else if (count_sat > MAX_BUFFERS)   st = ST_TOOMANY;
               else begin
                  hdr_end = HDR_BASE + ENTRY_BYTES * count_sat;
                  st      = (hdr_end > held_len) ? ST_HDRLONG : ST_MORE;
               end
               parse_stage = STAGE_ENTRY;
               word_pos    = FIELD_TYPE;
            end
            default: begin
               case (word_pos)
                  FIELD_TYPE:   begin cur_kind   = word; st = ST_MORE; end
                  FIELD_SIZE:   begin cur_size   = word; st = ST_MORE; end
                  FIELD_OFFSET: begin cur_offset = word; st = ST_MORE; end
                  default: begin
                     if (cur_offset[2:0] != 3'b000)          st = ST_ALIGN;
                     else if (word != 0)                     st = ST_HIGHOFF;
                     else if (cur_offset > held_len)         st = ST_PASTEND;
                     else if (cur_offset < hdr_end)          st = ST_INHDR;
                     else if (cur_size > held_len - cur_offset) st = ST_SIZE;
                     else begin
                        st = ST_MORE;
                        if (cur_kind == TYPE_SERVER)       slot = SLOT_SERVER;
                        else if (cur_kind == TYPE_PRIVSVR) slot = SLOT_PRIVSVR;
                        else if (cur_kind == TYPE_LOGON)   slot = SLOT_LOGON;
                        else                               slot = SLOT_NONE;
                        if (slot != SLOT_NONE) begin
                           if (seen[slot]) begin
                              case (slot)
                                 SLOT_SERVER:  st = ST_DUP_SERVER;
                                 SLOT_PRIVSVR: st = ST_DUP_PRIVSVR;
                                 default:      st = ST_DUP_LOGON;
                              endcase
                           end else begin
                              seen[slot]     = 1'b1;
                              seen_idx[slot] = IDX_W'(entries_done);
                           end
                        end
                        if (st == ST_MORE) begin
                           entries_done++;
                           if (entries_done >= count_sat) st = ST_ACCEPT;
                        end
                     end
                  end
               endcase
               word_pos = word_pos + 2'd1;
            end
         endcase
         if (st != ST_MORE) in_blob = 1'b0;
      end
      r.status = st;
      if (st == ST_ACCEPT) begin
         r.has_server  = seen[SLOT_SERVER];
         r.has_privsvr = seen[SLOT_PRIVSVR];
         r.has_logon   = seen[SLOT_LOGON];
         r.server_idx  = seen_idx[SLOT_SERVER];
         r.privsvr_idx = seen_idx[SLOT_PRIVSVR];
         r.logon_idx   = seen_idx[SLOT_LOGON];
      end
      return r;
   endfunction

   // mostly short idle stretches, now and then a long one
   function automatic int idle_length();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 80) return $urandom_range(1, 3);
      if (pick < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   function automatic int sender_gap();
      if (sender_burst > 0) begin
         sender_burst--;
         return 0;
      end
      if ($urandom_range(0, 199) == 0) sender_burst = $urandom_range(30, 120);
      if ($urandom_range(0, 3) == 0) return idle_length();
      return 0;
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      mismatch_count++;
      if (mismatch_count <= 40)
         $display("%0t: %s mismatch, got %0h, expected %0h", $time, what, got, want);
   endtask

   // one word through the req_ channel, entered and left at a falling edge
   task automatic send_word(bit start, logic [31:0] word, logic [31:0] len,
                            bit typed, status_type want);
      rsp_type predicted;
      rsp_type typed_rsp;
      int      gap;
      gap = sender_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= start;
      req_tdata  <= {len, word};
      do @(posedge clock); while (!req_tready);
      predicted = predict_word(start, word, len);
      if (typed) begin
         typed_rsp        = '0;
         typed_rsp.status = want;
         awaited_rsp.push_back(typed_rsp);
      end else begin
         awaited_rsp.push_back(predicted);
      end
      sent_words++;
      @(negedge clock);
   endtask

   // one random blob: mostly well formed, sometimes with one flawed entry,
   // sometimes cut short so that the next start abandons it
   task automatic send_random_blob();
      logic [31:0]     blob [$];
      logic [31:0]     count, len, hdr, off, size, kind, high;
      logic [63:0]     room, avail;
      int unsigned     entries, pick, bad_entry, e, sent;
      logic [2:0]      used;
      bit              corrupt, bad;
      status_type      flaw;
      used = '0;
      pick = $urandom_range(0, 99);
      if (pick < 80)      count = $urandom_range(1, 4);
      else if (pick < 88) count = $urandom_range(5, MAX_BUFFERS - 1);
      else if (pick < 90) count = MAX_BUFFERS;
      else if (pick < 94) count = 0;
      else if (pick < 96) count = MAX_BUFFERS + 1;
      else                count = $urandom_range(MAX_BUFFERS + 2, 32'hFFFF_FFFF);
      entries = (count <= MAX_BUFFERS) ? count : 0;
      hdr     = HDR_BASE + ENTRY_BYTES * ((entries == 0) ? 1 : entries);

      pick = $urandom_range(0, 99);
      if (pick < 70)      len = hdr + 8 * $urandom_range(0, 4 * entries + 2)
                                + $urandom_range(0, 7);
      else if (pick < 85) len = $urandom_range(hdr, 32'hFFFF_FFFF);
      else if (pick < 93) len = hdr - $urandom_range(1, 8);   // header too long
      else                len = $urandom_range(0, 11);        // truncated blob

      blob.push_back(count);
      blob.push_back(($urandom_range(0, 19) == 0) ? ($urandom | 32'h1) : 32'h0);

      corrupt   = ($urandom_range(0, 4) == 0);
      bad_entry = $urandom_range(0, (entries == 0) ? 0 : entries - 1);
      flaw      = status_type'($urandom_range(ST_ALIGN, ST_DUP_SERVER));
      for (e = 0; e < entries; e++) begin
         bad  = corrupt && (e == bad_entry);
         pick = $urandom_range(0, 5);
         if (pick == 0)      kind = TYPE_SERVER;
         else if (pick == 1) kind = TYPE_PRIVSVR;
         else if (pick == 2) kind = TYPE_LOGON;
         else if (pick == 3) kind = $urandom_range(0, 15);
         else                kind = $urandom;
         // special types stay unique unless a repeat is wanted here
         if (bad && flaw == ST_DUP_SERVER && used != 0) begin
            kind = used[0] ? TYPE_SERVER : used[1] ? TYPE_PRIVSVR : TYPE_LOGON;
         end else if (kind == TYPE_SERVER) begin
            if (used[0]) kind = 32'd1; else used[0] = 1'b1;
         end else if (kind == TYPE_PRIVSVR) begin
            if (used[1]) kind = 32'd1; else used[1] = 1'b1;
         end else if (kind == TYPE_LOGON) begin
            if (used[2]) kind = 32'd1; else used[2] = 1'b1;
         end

         room = (len >= hdr) ? (64'(len) - 64'(hdr)) >> 3 : 64'd0;
         pick = $urandom_range(0, 9);
         if (pick == 0)      off = hdr;
         else if (pick == 1) off = hdr + 32'(room << 3);
         else                off = hdr + 32'((64'($urandom) % (room + 1)) << 3);
         avail = (len >= off) ? 64'(len) - 64'(off) : 64'd0;
         pick  = $urandom_range(0, 9);
         if (pick == 0)      size = 32'(avail);
         else if (pick == 1) size = 32'd0;
         else                size = 32'(64'($urandom) % (avail + 1));
         high = 32'd0;

         if (bad) begin
            case (flaw)
               ST_ALIGN: begin
                  off = $urandom;
                  if (off[2:0] == 3'b000) off[0] = 1'b1;
               end
               ST_HIGHOFF: begin
                  high = $urandom;
                  if (high == 0) high = 32'h8000_0000;
               end
               ST_PASTEND:
                  if (len < 32'hFFFF_FFF8) off = {len[31:3] + 29'd1, 3'b000};
               ST_INHDR:
                  off = hdr - 8 * $urandom_range(1, hdr / 8);
               ST_SIZE:
                  if (avail < 64'hFFFF_FFFF)
                     size = $urandom_range(32'(avail) + 1, 32'hFFFF_FFFF);
               default: ;
            endcase
         end
         blob.push_back(kind);
         blob.push_back(size);
         blob.push_back(off);
         blob.push_back(high);
      end

      sent = ($urandom_range(0, 9) == 0) ? $urandom_range(1, blob.size() - 1)
                                         : blob.size();
      for (e = 0; e < sent; e++)
         send_word(e == 0, blob[e], (e == 0) ? len : $urandom, 1'b0, ST_IDLE);
      // stray words between blobs
      if ($urandom_range(0, 19) == 0)
         repeat ($urandom_range(1, 3)) send_word(1'b0, $urandom, $urandom, 1'b0, ST_IDLE);
   endtask

   // ------------------------------------------------------------------------
   // stimulus
   // ------------------------------------------------------------------------
   initial begin : stimulus
      int i;
      bit hold_done;
      bit drain_done;
      hold_done  = 1'b0;
      drain_done = 1'b0;
      clear_parse();
      repeat (5) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      for (i = 0; i < $size(directed_rows); i++)
         send_word(directed_rows[i].start, directed_rows[i].word, directed_rows[i].len,
                   directed_rows[i].typed, directed_rows[i].want);

      while (sent_words < TOTAL_WORDS) begin
         // long receiver hold-off while words keep coming
         if (!hold_done && sent_words >= 250) begin
            hold_done     = 1'b1;
            sink_hold_req = 1'b1;
         end
         // sender pause until every result is back
         if (!drain_done && sent_words >= 550) begin
            drain_done = 1'b1;
            req_tvalid <= 1'b0;
            wait (awaited_rsp.size() == 0);
            @(negedge clock);
         end
         send_random_blob();
      end

      req_tvalid <= 1'b0;
      wait (awaited_rsp.size() == 0);
      repeat (DRAIN_SLACK) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("** pac_header_validator: PASSED **");
      end else begin
         $display("** pac_header_validator: FAILED **");
      end
      $finish;
   end

   // ------------------------------------------------------------------------
   // result receiver: random stalls, steady stretches, one long hold-off
   // ------------------------------------------------------------------------
   initial begin : sink
      int stall_left;
      int steady_left;
      stall_left  = 0;
      steady_left = 0;
      forever begin
         @(negedge clock);
         if (sink_hold_req) begin
            stall_left    = SINK_HOLD_CYCLES;
            sink_hold_req = 1'b0;
         end
         if (stall_left > 0) begin
            rsp_tready <= 1'b0;
            stall_left--;
         end else begin
            rsp_tready <= 1'b1;
            if (steady_left > 0) steady_left--;
            else if ($urandom_range(0, 149) == 0) steady_left = $urandom_range(40, 150);
            else if ($urandom_range(0, 2) == 0) stall_left = idle_length();
         end
      end
   end

   // ------------------------------------------------------------------------
   // result check, one transfer against the oldest prediction
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : rsp_check
      rsp_type got;
      rsp_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata;
         if (awaited_rsp.size() == 0) begin
            report_mismatch("unexpected transfer", rsp_tdata, 32'd0);
         end else begin
            want = awaited_rsp.pop_front();
            if (got.status !== want.status)
               report_mismatch("status", 32'(got.status), 32'(want.status));
            if (got.has_server !== want.has_server)
               report_mismatch("has_server_sum", 32'(got.has_server),
                               32'(want.has_server));
            if (got.has_privsvr !== want.has_privsvr)
               report_mismatch("has_privsvr_sum", 32'(got.has_privsvr),
                               32'(want.has_privsvr));
            if (got.has_logon !== want.has_logon)
               report_mismatch("has_logon_name", 32'(got.has_logon),
                               32'(want.has_logon));
            if (got.server_idx !== want.server_idx)
               report_mismatch("server_sum_index", 32'(got.server_idx),
                               32'(want.server_idx));
            if (got.privsvr_idx !== want.privsvr_idx)
               report_mismatch("privsvr_sum_index", 32'(got.privsvr_idx),
                               32'(want.privsvr_idx));
            if (got.logon_idx !== want.logon_idx)
               report_mismatch("logon_name_index", 32'(got.logon_idx),
                               32'(want.logon_idx));
            if (got.pad !== want.pad)
               report_mismatch("zero bits", 32'(got.pad), 32'(want.pad));
         end
      end
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("** pac_header_validator: FAILED **");
         $finish;
      end
   end

endmodule
